[hw/rtl/assert_macros.svh]
// Assertion macros used by the port-level checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst is high.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst is high.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bwwg_pkg.sv]
// Shared types, constants and helpers of the bilinear warp weight generator.
package bwwg_pkg;

  localparam int POS_W        = 10;
  localparam int BATCH_W      = 4;
  localparam int DISP_W       = 20;
  localparam int SIDE_W       = 11;
  localparam int INDEX_W      = 24;
  localparam int WEIGHT_W     = 13;
  localparam int WEIGHT_FRAC  = 12;
  localparam int CFG_IDX_W    = 1;

  localparam int FRAC_BITS_DEF = 12;
  localparam int MAX_SIDE      = 1024;
  localparam int MAX_BATCH     = 16;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_PX  = 1'b0,
    REG_HEIGHT_PX = 1'b1
  } cfg_reg_t;

  // Which axes are wider than one pixel; a size-one axis has no ceiling neighbor.
  typedef struct packed {
    logic has_x;
    logic has_y;
  } bwwg_axes_t;

  function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (32'(v) > MAX_SIDE) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

endpackage

[hw/rtl/bwwg_emit.sv]
// Neighbor sequencer: holds one pixel and emits its neighbors through the output register.
module bwwg_emit import bwwg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bwwg_axes_t           axes,
  input  logic                 ld_valid,
  output logic                 ld_ready,
  input  logic [INDEX_W-1:0]   ld_pix,
  input  logic [INDEX_W-1:0]   ld_rb0,
  input  logic [INDEX_W-1:0]   ld_rb1,
  input  logic [SIDE_W-1:0]    ld_col0,
  input  logic [SIDE_W-1:0]    ld_col1,
  input  logic [FRAC_BITS-1:0] ld_frx,
  input  logic [FRAC_BITS-1:0] ld_fry,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [INDEX_W-1:0]   sample_index,
  output logic [INDEX_W-1:0]   pixel_index,
  output logic [WEIGHT_W-1:0]  weight,
  output logic                 last
);

  localparam int FW    = FRAC_BITS + 1;
  localparam int PW    = 2 * FW;
  localparam int EW    = PW + WEIGHT_W + WEIGHT_FRAC;
  localparam int SH_R  = (2 * FRAC_BITS >= WEIGHT_FRAC) ? 2 * FRAC_BITS - WEIGHT_FRAC : 0;
  localparam int SH_L  = (2 * FRAC_BITS <  WEIGHT_FRAC) ? WEIGHT_FRAC - 2 * FRAC_BITS : 0;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  logic                 d_valid;
  logic [1:0]           sel;
  logic [INDEX_W-1:0]   d_pix, d_rb0, d_rb1;
  logic [SIDE_W-1:0]    d_col0, d_col1;
  logic [FRAC_BITS-1:0] d_frx, d_fry;

  logic                 sx, sy, d_last, o_load, fire;
  logic [FW-1:0]        fx, fy;
  logic [PW-1:0]        prod;
  logic [EW-1:0]        prod_ext;
  logic [INDEX_W-1:0]   sample_next;
  logic [WEIGHT_W-1:0]  weight_next;

  assign sx     = sel[0];
  assign sy     = sel[1];
  assign d_last = (!axes.has_x || sx) && (!axes.has_y || sy);
  assign o_load = !out_valid || !out_stall;
  assign fire   = d_valid && o_load;
  assign ld_ready = !d_valid || (fire && d_last);

  always_comb begin
    fx = sx ? {1'b0, d_frx} : ONE - {1'b0, d_frx};
    fy = sy ? {1'b0, d_fry} : ONE - {1'b0, d_fry};
    prod = {{FW{1'b0}}, fx} * {{FW{1'b0}}, fy};
    prod_ext = {{(WEIGHT_W + WEIGHT_FRAC){1'b0}}, prod};
    // rescale to the output fraction, truncating dropped bits
    weight_next = WEIGHT_W'((prod_ext >> SH_R) << SH_L);
    sample_next = (sy ? d_rb1 : d_rb0) + {{(INDEX_W-SIDE_W){1'b0}}, sx ? d_col1 : d_col0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      sel     <= 2'd0;
    end else if (ld_ready) begin
      d_valid <= ld_valid;
      sel     <= 2'd0;
    end else if (fire) begin
      // skip ceiling neighbors along a size-one x axis
      sel <= axes.has_x ? sel + 2'd1 : sel + 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ready && ld_valid) begin
      d_pix  <= ld_pix;
      d_rb0  <= ld_rb0;
      d_rb1  <= ld_rb1;
      d_col0 <= ld_col0;
      d_col1 <= ld_col1;
      d_frx  <= ld_frx;
      d_fry  <= ld_fry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sample_index <= sample_next;
      pixel_index  <= d_pix;
      weight       <= weight_next;
      last         <= d_last;
    end
  end

endmodule

[hw/rtl/bilinear_warp_weight_generator_core.sv]
// Top level of the bilinear warp weight generator.
// Usage:
//   Input requests carry one output pixel (pos_x, pos_y, batch_id) and its
//   displacement (disp_x, disp_y, signed, FRAC_BITS fraction bits). A request
//   is taken on an edge with in_valid high and in_stall low.
//   Each pixel that lands inside the image interior yields one result per
//   neighbor: four on a 2-D image, two when one side is a single pixel, one
//   when both are. Pixels outside give nothing. The last result of a pixel
//   carries last = 1. Results leave when out_valid is high and out_stall low.
//   A pixel's first result passes three compute stages, the neighbor sequencer
//   and the output register. Throughput: one result per cycle unless stalled,
//   set by the single output port; a pixel holds the sequencer until its last
//   result is sent, and a rejected pixel never enters it. Requests are taken
//   every cycle while the sequencer keeps up. A stalled receiver holds the
//   output register; the stall backs up through the stages into in_stall, and
//   nothing is dropped or repeated. The user writes the size registers on
//   the cfg channel (always ready) only while the block is idle; the block
//   does not enforce it. Reset empties all stages and sets both sizes to 1024.
module bilinear_warp_weight_generator_core import bwwg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [POS_W-1:0]     pos_x,
  input  logic [POS_W-1:0]     pos_y,
  input  logic [BATCH_W-1:0]   batch_id,
  input  logic signed [DISP_W-1:0] disp_x,
  input  logic signed [DISP_W-1:0] disp_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [INDEX_W-1:0]   sample_index,
  output logic [INDEX_W-1:0]   pixel_index,
  output logic [WEIGHT_W-1:0]  weight,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data
);

  localparam int CW = ((SIDE_W + FRAC_BITS > DISP_W) ? SIDE_W + FRAC_BITS : DISP_W) + 2;
  localparam int WH_W = 2 * SIDE_W;

  logic [SIDE_W-1:0] width_px, height_px;
  bwwg_axes_t        axes;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_px  <= SIDE_RESET;
      height_px <= SIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH_PX:  width_px  <= sat_side(cfg_data);
        REG_HEIGHT_PX: height_px <= sat_side(cfg_data);
        default: ;
      endcase
    end
  end

  assign axes.has_x = (width_px  != SIDE_W'(1));
  assign axes.has_y = (height_px != SIDE_W'(1));

  // stage A: registered request
  logic                 a_valid;
  logic [POS_W-1:0]     a_px, a_py;
  logic [BATCH_W-1:0]   a_b;
  logic [DISP_W-1:0]    a_dx, a_dy;

  // stage B: split coordinates
  logic                 b_valid;
  logic [BATCH_W-1:0]   b_b;
  logic [POS_W-1:0]     b_px;
  logic [WH_W-2:0]      b_pyw;
  logic [WH_W-1:0]      b_wh;
  logic [SIDE_W-1:0]    b_flx, b_fly;
  logic [FRAC_BITS-1:0] b_frx, b_fry;

  // stage C: products
  logic                 c_valid;
  logic [INDEX_W-1:0]   c_base, c_row0, c_pixoff;
  logic [SIDE_W-1:0]    c_flx;
  logic [FRAC_BITS-1:0] c_frx, c_fry;

  logic a_take, b_take, c_take, d_ready;

  assign c_take   = !c_valid || d_ready;
  assign b_take   = !b_valid || c_take;
  assign a_take   = !a_valid || b_take;
  assign in_stall = !a_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_take) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && in_valid) begin
      a_px <= pos_x;
      a_py <= pos_y;
      a_b  <= batch_id;
      a_dx <= disp_x;
      a_dy <= disp_y;
    end
  end

  // A -> B: displaced position, interior check, size products
  logic [CW-1:0]     cx, cy, lim_x, lim_y;
  logic [SIDE_W-1:0] wm1, hm1;
  logic              x_ok, y_ok, in_ok;
  logic [WH_W-1:0]   wh_c, pyw_c;

  always_comb begin
    wm1 = width_px - SIDE_W'(1);
    hm1 = height_px - SIDE_W'(1);
    cx = {{(CW-POS_W-FRAC_BITS){1'b0}}, a_px, {FRAC_BITS{1'b0}}}
       + {{(CW-DISP_W){a_dx[DISP_W-1]}}, a_dx};
    cy = {{(CW-POS_W-FRAC_BITS){1'b0}}, a_py, {FRAC_BITS{1'b0}}}
       + {{(CW-DISP_W){a_dy[DISP_W-1]}}, a_dy};
    lim_x = {{(CW-SIDE_W-FRAC_BITS){1'b0}}, wm1, {FRAC_BITS{1'b0}}};
    lim_y = {{(CW-SIDE_W-FRAC_BITS){1'b0}}, hm1, {FRAC_BITS{1'b0}}};
    x_ok = !axes.has_x || (!cx[CW-1] && cx < lim_x);
    y_ok = !axes.has_y || (!cy[CW-1] && cy < lim_y);
    in_ok = ({1'b0, a_px} < width_px) && ({1'b0, a_py} < height_px)
         && (32'(a_b) < MAX_BATCH) && x_ok && y_ok;
    wh_c  = {{SIDE_W{1'b0}}, width_px} * {{SIDE_W{1'b0}}, height_px};
    pyw_c = {{(WH_W-POS_W){1'b0}}, a_py} * {{SIDE_W{1'b0}}, width_px};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_take) begin
      // drop pixels that give no result
      b_valid <= a_valid && in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take && a_valid) begin
      b_b   <= a_b;
      b_px  <= a_px;
      b_pyw <= pyw_c[WH_W-2:0];
      b_wh  <= wh_c;
      b_flx <= cx[FRAC_BITS +: SIDE_W];
      b_fly <= cy[FRAC_BITS +: SIDE_W];
      b_frx <= cx[FRAC_BITS-1:0];
      b_fry <= cy[FRAC_BITS-1:0];
    end
  end

  // B -> C: batch offset and row offset
  logic [SIDE_W-1:0]  fly_eff;
  logic [INDEX_W-1:0] base_c, row0_c, pixoff_c;

  always_comb begin
    // a size-one axis clamps its floor neighbor to 0
    fly_eff  = axes.has_y ? b_fly : '0;
    base_c   = INDEX_W'({{(INDEX_W-BATCH_W){1'b0}}, b_b} * {{(INDEX_W-WH_W){1'b0}}, b_wh});
    row0_c   = INDEX_W'({{(INDEX_W-SIDE_W){1'b0}}, fly_eff}
                      * {{(INDEX_W-SIDE_W){1'b0}}, width_px});
    pixoff_c = {{(INDEX_W-WH_W+1){1'b0}}, b_pyw} + {{(INDEX_W-POS_W){1'b0}}, b_px};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_take) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_take && b_valid) begin
      c_base   <= base_c;
      c_row0   <= row0_c;
      c_pixoff <= pixoff_c;
      c_flx    <= axes.has_x ? b_flx : '0;
      c_frx    <= b_frx;
      c_fry    <= b_fry;
    end
  end

  // C -> sequencer: final index bases
  logic [INDEX_W-1:0] pix_c, rb0_c, rb1_c;
  logic [SIDE_W-1:0]  col1_c;

  always_comb begin
    pix_c  = c_base + c_pixoff;
    rb0_c  = c_base + c_row0;
    rb1_c  = c_base + c_row0 + {{(INDEX_W-SIDE_W){1'b0}}, width_px};
    col1_c = c_flx + SIDE_W'(1);
  end

  bwwg_emit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .axes         (axes),
    .ld_valid     (c_valid),
    .ld_ready     (d_ready),
    .ld_pix       (pix_c),
    .ld_rb0       (rb0_c),
    .ld_rb1       (rb1_c),
    .ld_col0      (c_flx),
    .ld_col1      (col1_c),
    .ld_frx       (c_frx),
    .ld_fry       (c_fry),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_index (sample_index),
    .pixel_index  (pixel_index),
    .weight       (weight),
    .last         (last)
  );

endmodule

[hw/rtl/bwwg_checker.sv]
// Port-level checks of the bilinear warp weight generator, bound to the top level.
`include "assert_macros.svh"

module bwwg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] sample_index,
  input logic [23:0] pixel_index,
  input logic [12:0] weight,
  input logic        last
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(sample_index) && $stable(pixel_index) && $stable(weight)
      && $stable(last), "stalled result changed")

  // the output register comes out of reset empty
  `ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "result shown right after reset")

  // a weight never exceeds one
  `ASSERT_NOW(a_weight_max, out_valid, weight <= 13'd4096, "weight above one")

  // neighbors of one pixel follow back to back with the same pixel index
  `ASSERT_NEXT(a_group_cont, out_valid && !out_stall && !last,
    out_valid && $stable(pixel_index), "pixel group broken")

endmodule

bind bilinear_warp_weight_generator_core bwwg_checker u_bwwg_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .sample_index (sample_index),
  .pixel_index  (pixel_index),
  .weight       (weight),
  .last         (last)
);

[tb/bwwg_neighbor_checker.sv]
// Checker for the bilinear warp weight generator: predicts neighbor results and compares them.
module bwwg_neighbor_checker import bwwg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [POS_W-1:0]         pos_x,
  input  logic [POS_W-1:0]         pos_y,
  input  logic [BATCH_W-1:0]       batch_id,
  input  logic signed [DISP_W-1:0] disp_x,
  input  logic signed [DISP_W-1:0] disp_y,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [INDEX_W-1:0]       sample_index,
  input  logic [INDEX_W-1:0]       pixel_index,
  input  logic [WEIGHT_W-1:0]      weight,
  input  logic                     last,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SIDE_W-1:0]        cfg_data,
  output int                       mismatches,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC = FRAC_BITS_DEF;
  localparam longint ONE  = longint'(1) << FRAC;

  typedef struct packed {
    logic [INDEX_W-1:0]  sample_index;
    logic [INDEX_W-1:0]  pixel_index;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } neighbor_t;

  neighbor_t pending_neighbors[$];
  longint    side_x = MAX_SIDE;
  longint    side_y = MAX_SIDE;

  initial mismatches = 0;
  initial pending = 0;

  function automatic longint clip_side(input logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (longint'(v) > MAX_SIDE) return MAX_SIDE;
    return longint'(v);
  endfunction

  // Floor and fraction of a displaced coordinate; false when outside the interior.
  function automatic bit axis_split(input longint co, input longint side,
                                    output longint fl, output longint fr);
    fr = co & (ONE - 1);
    fl = co >>> FRAC;
    return side == 1 || (co >= 0 && co < (side - 1) * ONE);
  endfunction

  function automatic longint clamp_to(input longint v, input longint side);
    if (v < 0) return 0;
    if (v > side - 1) return side - 1;
    return v;
  endfunction

  function automatic void predict_pixel(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                        input logic [BATCH_W-1:0] b,
                                        input logic signed [DISP_W-1:0] dx,
                                        input logic signed [DISP_W-1:0] dy);
    longint    cx, cy, flx, fly, frx, fry, base, pix, ix, iy, fx, fy, total;
    int        made;
    neighbor_t nb;
    if (px >= side_x || py >= side_y || b >= MAX_BATCH) return;
    cx = (longint'(px) << FRAC) + longint'(dx);
    cy = (longint'(py) << FRAC) + longint'(dy);
    if (!axis_split(cx, side_x, flx, frx)) return;
    if (!axis_split(cy, side_y, fly, fry)) return;
    base  = longint'(b) * side_x * side_y;
    pix   = base + longint'(py) * side_x + longint'(px);
    total = (side_x > 1 ? 2 : 1) * (side_y > 1 ? 2 : 1);
    made  = 0;
    // Neighbor order: floor/floor, ceil x, ceil y, ceil both.
    for (int k = 0; k < 4; k++) begin
      bit step_x, step_y;
      step_x = k[0];
      step_y = k[1];
      if ((step_x && side_x == 1) || (step_y && side_y == 1)) continue;
      ix = clamp_to(step_x ? flx + 1 : flx, side_x);
      iy = clamp_to(step_y ? fly + 1 : fly, side_y);
      fx = step_x ? frx : ONE - frx;
      fy = step_y ? fry : ONE - fry;
      nb.sample_index = INDEX_W'(base + iy * side_x + ix);
      nb.pixel_index  = INDEX_W'(pix);
      nb.weight       = WEIGHT_W'((fx * fy) >>> (2 * FRAC - WEIGHT_FRAC));
      made++;
      nb.last = (made == total);
      pending_neighbors.push_back(nb);
    end
  endfunction

  always @(posedge clk) begin
    neighbor_t want;
    bit        bad;
    if (rst) begin
      side_x = MAX_SIDE;
      side_y = MAX_SIDE;
      pending_neighbors.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_WIDTH_PX:  side_x = clip_side(cfg_data);
          REG_HEIGHT_PX: side_y = clip_side(cfg_data);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_neighbors.size() == 0) begin
          $display("%0t: unexpected result sample_index %0d pixel_index %0d weight %0d last %0b",
                   $time, sample_index, pixel_index, weight, last);
          mismatches++;
        end else begin
          want = pending_neighbors.pop_front();
          bad  = 1'b0;
          if (sample_index !== want.sample_index) begin
            $display("%0t: sample_index expected %0d actual %0d",
                     $time, want.sample_index, sample_index);
            bad = 1'b1;
          end
          if (pixel_index !== want.pixel_index) begin
            $display("%0t: pixel_index expected %0d actual %0d",
                     $time, want.pixel_index, pixel_index);
            bad = 1'b1;
          end
          if (weight !== want.weight) begin
            $display("%0t: weight expected %0d actual %0d", $time, want.weight, weight);
            bad = 1'b1;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            bad = 1'b1;
          end
          if (bad) mismatches++;
        end
      end
      if (in_valid && !in_stall) predict_pixel(pos_x, pos_y, batch_id, disp_x, disp_y);
    end
    pending = pending_neighbors.size();
  end

endmodule

[tb/bilinear_warp_weight_generator_core_tb.sv]
// Testbench top of the bilinear warp weight generator: stimulus, idling and verdict.
module bilinear_warp_weight_generator_core_tb import bwwg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [POS_W-1:0]         pos_x = '0;
  logic [POS_W-1:0]         pos_y = '0;
  logic [BATCH_W-1:0]       batch_id = '0;
  logic signed [DISP_W-1:0] disp_x = '0;
  logic signed [DISP_W-1:0] disp_y = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [INDEX_W-1:0]       sample_index;
  logic [INDEX_W-1:0]       pixel_index;
  logic [WEIGHT_W-1:0]      weight;
  logic                     last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_WIDTH_PX;
  logic [SIDE_W-1:0]        cfg_data = '0;
  int                       mismatches;
  int                       pending;

  // Effective sizes, used only to aim the random requests at the image interior.
  int cur_w = MAX_SIDE;
  int cur_h = MAX_SIDE;
  bit quiet = 1'b0;

  bilinear_warp_weight_generator_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .batch_id(batch_id), .disp_x(disp_x), .disp_y(disp_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_index(sample_index), .pixel_index(pixel_index), .weight(weight), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bwwg_neighbor_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .batch_id(batch_id), .disp_x(disp_x), .disp_y(disp_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_index(sample_index), .pixel_index(pixel_index), .weight(weight), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 21);
    end
  end

  // Enter and leave at a falling edge; valid stays high after the request is taken.
  task automatic send_pixel(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic [BATCH_W-1:0] b,
                            input logic signed [DISP_W-1:0] dx,
                            input logic signed [DISP_W-1:0] dy);
    if (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    pos_x    <= px;
    pos_y    <= py;
    batch_id <= b;
    disp_x   <= dx;
    disp_y   <= dy;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off requests until every expected result is back, then let the pipeline empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [SIDE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_sizes(input int wv, input int hv);
    write_reg(REG_WIDTH_PX, SIDE_W'(wv));
    write_reg(REG_HEIGHT_PX, SIDE_W'(hv));
    cfg_valid <= 1'b0;
    cur_w = (wv == 0) ? 1 : (wv > MAX_SIDE ? MAX_SIDE : wv);
    cur_h = (hv == 0) ? 1 : (hv > MAX_SIDE ? MAX_SIDE : hv);
  endtask

  // Displacement that lands the pixel inside the interior, sometimes on an exact position.
  function automatic logic signed [DISP_W-1:0] aimed_disp(input int p, input int side);
    longint lo, hi, co, here;
    if (side == 1) return DISP_W'($urandom);
    here = longint'(p) << FRAC_BITS_DEF;
    lo = here - 524288;
    if (lo < 0) lo = 0;
    hi = here + 524287;
    if (hi > (longint'(side - 1) << FRAC_BITS_DEF) - 1)
      hi = (longint'(side - 1) << FRAC_BITS_DEF) - 1;
    co = lo + $urandom_range(int'(hi - lo), 0);
    if ($urandom_range(99) < 15) co = co & ~((longint'(1) << FRAC_BITS_DEF) - 1);
    return DISP_W'(co - here);
  endfunction

  task automatic random_pixel();
    logic [POS_W-1:0] px, py;
    logic signed [DISP_W-1:0] dx, dy;
    if ($urandom_range(99) < 20) begin
      px = POS_W'($urandom);
      py = POS_W'($urandom);
      dx = DISP_W'($urandom);
      dy = DISP_W'($urandom);
    end else begin
      px = POS_W'($urandom_range(cur_w - 1, 0));
      py = POS_W'($urandom_range(cur_h - 1, 0));
      dx = aimed_disp(int'(px), cur_w);
      dy = aimed_disp(int'(py), cur_h);
    end
    send_pixel(px, py, BATCH_W'($urandom), dx, dy);
  endtask

  task automatic random_phase(input int wv, input int hv, input int count);
    set_sizes(wv, hv);
    repeat (count) random_pixel();
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset sizes: corners, edges, extremes of the displacement.
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(1023, 1023, 15, -1, -1);
    send_pixel(1023, 0, 0, 0, 0);
    send_pixel(0, 0, 0, -1, 0);
    send_pixel(0, 0, 0, 0, -1);
    send_pixel(5, 7, 3, 2048, -2048);
    send_pixel(200, 300, 9, -524288, 524287);
    send_pixel(0, 0, 0, 524287, 0);
    send_pixel(1023, 1023, 15, -524288, -524288);
    send_pixel(100, 100, 5, 20'sh55555, 20'shAAAAA);
    send_pixel(512, 511, 10, 4096, 4095);
    drain();
    quiet = 1'b1;
    repeat (50) random_pixel();
    drain();
    quiet = 1'b0;

    // Single-pixel image: a zero write saturates to one.
    set_sizes(0, 0);
    send_pixel(0, 0, 15, -524288, 524287);
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(1, 0, 0, 0, 0);
    send_pixel(0, 0, 7, 4095, 1);
    repeat (30) random_pixel();
    drain();

    random_phase(1, 2047, 40);
    random_phase(1500, 1, 40);
    random_phase(2, 2, 50);

    set_sizes(17, 9);
    send_pixel(20, 3, 1, 0, 0);
    send_pixel(3, 9, 1, 0, 0);
    send_pixel(16, 8, 2, -1, -1);
    send_pixel(15, 7, 2, 4096, 0);
    repeat (60) random_pixel();
    drain();

    repeat (3) random_phase($urandom_range(64, 1), $urandom_range(64, 1), 35);
    random_phase(640, 480, 50);
    random_phase(1024, 1024, 40);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
